FILE: hw/rtl/dttq_pkg.sv
// ---------------------------------------------------------------------------
// dttq_pkg
// Shared sizes, codes and control types for the delayed task timer queue.
// ---------------------------------------------------------------------------
package dttq_pkg;

	localparam int SLOTS     = 8;
	localparam int TICK_BITS = 16;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = $clog2(SLOTS + 1);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TICK_BITS-1:0] tick_t;

	localparam idx_t NONE_IDX = IDX_W'(SLOTS);

	localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

	localparam logic [1:0] FUNC_SCHED = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_POP   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_FULL,
		OP_TAKE,
		OP_TICK,
		OP_EMPTY,
		OP_POP,
		OP_ADV,
		OP_INS1,
		OP_INS2,
		OP_APPA,
		OP_APPB,
		OP_TPOP,
		OP_POP2,
		OP_FINISH
	} dttq_op_t;

	typedef struct packed {
		dttq_op_t op;
	} dttq_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       free_none;
		logic       ready_none;
		logic       ready_last_none;
		logic       prev_none;
		logic       delay_zero;
		logic       scan_go;
		logic       due;
		logic       out_free;
	} dttq_sts_t;

	function automatic logic [3:0] sat4(input cnt_t c);
		return (32'(c) > 32'd15) ? 4'hF : 4'(c);
	endfunction

endpackage

FILE: hw/rtl/dttq_ctrl.sv
// ---------------------------------------------------------------------------
// dttq_ctrl
// Sequencer: walks one request through the list operations of the datapath.
// ---------------------------------------------------------------------------
module dttq_ctrl import dttq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dttq_sts_t sts,
	output dttq_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_SCAN,
		ST_INS2,
		ST_APPA,
		ST_APPB,
		ST_TCHK,
		ST_POP2,
		ST_FIN
	} state_t;

	state_t   state_q;
	state_t   state_d;
	dttq_op_t op;
	logic     tick_mode;

	assign tick_mode = (sts.func == FUNC_TICK);
	assign s_tready  = (state_q == ST_IDLE);
	assign cmd.op    = op;

	always_comb begin
		op      = OP_NOP;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op      = OP_CAPTURE;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.func)
					FUNC_SCHED: begin
						if (sts.free_none) begin
							op      = OP_FULL;
							state_d = ST_FIN;
						end else begin
							op      = OP_TAKE;
							state_d = sts.delay_zero ? ST_APPA : ST_SCAN;
						end
					end
					FUNC_TICK: begin
						op      = OP_TICK;
						state_d = ST_TCHK;
					end
					FUNC_POP: begin
						if (sts.ready_none) begin
							op      = OP_EMPTY;
							state_d = ST_FIN;
						end else begin
							op      = OP_POP;
							state_d = ST_POP2;
						end
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_SCAN: begin
				if (sts.scan_go) begin
					op = OP_ADV;
				end else begin
					op      = OP_INS1;
					state_d = sts.prev_none ? ST_FIN : ST_INS2;
				end
			end
			ST_INS2: begin
				op      = OP_INS2;
				state_d = ST_FIN;
			end
			ST_APPA: begin
				op = OP_APPA;
				if (sts.ready_last_none) begin
					state_d = tick_mode ? ST_TCHK : ST_FIN;
				end else begin
					state_d = ST_APPB;
				end
			end
			ST_APPB: begin
				op      = OP_APPB;
				state_d = tick_mode ? ST_TCHK : ST_FIN;
			end
			ST_TCHK: begin
				if (sts.due) begin
					op      = OP_TPOP;
					state_d = ST_APPA;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_POP2: begin
				op      = OP_POP2;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					op      = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/dttq_dp.sv
// ---------------------------------------------------------------------------
// dttq_dp
// Slot store, list heads, counters and output word register.
// ---------------------------------------------------------------------------
module dttq_dp import dttq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dttq_cmd_t             cmd,
	output dttq_sts_t             sts,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser
);

	tick_t slot_deadline_q [SLOTS];
	logic [15:0] slot_handle_q [SLOTS];
	logic [15:0] slot_arg_q [SLOTS];
	idx_t slot_link_q [SLOTS];

	idx_t  free_first_q, wait_first_q, ready_first_q, ready_last_q;
	tick_t now_q;
	cnt_t  ready_cnt_q, free_cnt_q, moved_q;
	logic  m_tvalid_q;

	logic [1:0]  func_q;
	tick_t       d_q;
	logic        dzero_q;
	logic [15:0] hin_q, ain_q;
	idx_t        s_q, cur_q, prev_q;
	logic [1:0]  res_stat_q;
	logic [15:0] oh_q, oa_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic [15:0] in_delay;
	tick_t       in_d;
	idx_t        lk_ra, lk_rd;
	logic        lk_we;
	idx_t        lk_wa, lk_wd;
	idx_t        dl_ra;
	tick_t       dl_rd, rem;
	logic        out_free;

	assign in_delay = s_tdata[15:0];
	assign in_d = (33'(in_delay) > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0] : TICK_BITS'(in_delay);

	always_comb begin
		case (cmd.op)
			OP_TAKE: lk_ra = free_first_q;
			OP_TPOP: lk_ra = wait_first_q;
			OP_POP:  lk_ra = ready_first_q;
			default: lk_ra = cur_q;
		endcase
	end
	assign lk_rd = slot_link_q[lk_ra[SLOT_W-1:0]];

	always_comb begin
		lk_we = 1'b1;
		lk_wa = s_q;
		lk_wd = NONE_IDX;
		case (cmd.op)
			OP_INS1: lk_wd = cur_q;
			OP_INS2: begin
				lk_wa = prev_q;
				lk_wd = s_q;
			end
			OP_APPA: lk_wd = NONE_IDX;
			OP_APPB: begin
				lk_wa = ready_last_q;
				lk_wd = s_q;
			end
			OP_POP2: lk_wd = free_first_q;
			default: lk_we = 1'b0;
		endcase
	end

	assign dl_ra = (func_q == FUNC_TICK) ? wait_first_q : cur_q;
	assign dl_rd = slot_deadline_q[dl_ra[SLOT_W-1:0]];
	assign rem   = dl_rd - now_q;

	assign out_free = !m_tvalid_q || m_tready;

	assign sts.func            = func_q;
	assign sts.free_none       = (free_first_q == NONE_IDX);
	assign sts.ready_none      = (ready_first_q == NONE_IDX);
	assign sts.ready_last_none = (ready_last_q == NONE_IDX);
	assign sts.prev_none       = (prev_q == NONE_IDX);
	assign sts.delay_zero      = dzero_q;
	assign sts.scan_go         = (cur_q != NONE_IDX) && (rem < d_q);
	assign sts.due             = (wait_first_q != NONE_IDX) && (dl_rd == now_q);
	assign sts.out_free        = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_link_q[i] <= IDX_W'(i + 1);
			end
		end else if (lk_we) begin
			slot_link_q[lk_wa[SLOT_W-1:0]] <= lk_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE) begin
			slot_handle_q[free_first_q[SLOT_W-1:0]] <= hin_q;
			slot_arg_q[free_first_q[SLOT_W-1:0]]    <= ain_q;
		end
		if (cmd.op == OP_INS1) begin
			slot_deadline_q[s_q[SLOT_W-1:0]] <= now_q + d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_first_q  <= '0;
			wait_first_q  <= NONE_IDX;
			ready_first_q <= NONE_IDX;
			ready_last_q  <= NONE_IDX;
			now_q         <= '0;
			ready_cnt_q   <= '0;
			free_cnt_q    <= CNT_W'(SLOTS);
			moved_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CAPTURE: moved_q <= '0;
				OP_TAKE: begin
					free_first_q <= lk_rd;
					free_cnt_q   <= free_cnt_q - 1'b1;
				end
				OP_TICK: now_q <= now_q + 1'b1;
				OP_INS1: begin
					if (prev_q == NONE_IDX) begin
						wait_first_q <= s_q;
					end
				end
				OP_APPA: begin
					ready_cnt_q <= ready_cnt_q + 1'b1;
					if (ready_last_q == NONE_IDX) begin
						ready_first_q <= s_q;
						ready_last_q  <= s_q;
					end
				end
				OP_APPB: ready_last_q <= s_q;
				OP_TPOP: begin
					wait_first_q <= lk_rd;
					moved_q      <= moved_q + 1'b1;
				end
				OP_POP: begin
					ready_first_q <= lk_rd;
					ready_cnt_q   <= ready_cnt_q - 1'b1;
					if (lk_rd == NONE_IDX) begin
						ready_last_q <= NONE_IDX;
					end
				end
				OP_POP2: begin
					free_first_q <= s_q;
					free_cnt_q   <= free_cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_FINISH) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				func_q     <= s_tuser;
				d_q        <= in_d;
				dzero_q    <= (in_delay == 16'd0);
				hin_q      <= s_tdata[31:16];
				ain_q      <= s_tdata[47:32];
				res_stat_q <= STAT_OK;
				oh_q       <= '0;
				oa_q       <= '0;
			end
			OP_FULL:  res_stat_q <= STAT_FULL;
			OP_EMPTY: res_stat_q <= STAT_EMPTY;
			OP_TAKE: begin
				s_q    <= free_first_q;
				cur_q  <= wait_first_q;
				prev_q <= NONE_IDX;
			end
			OP_ADV: begin
				prev_q <= cur_q;
				cur_q  <= lk_rd;
			end
			OP_TPOP: s_q <= wait_first_q;
			OP_POP: begin
				s_q  <= ready_first_q;
				oh_q <= slot_handle_q[ready_first_q[SLOT_W-1:0]];
				oa_q <= slot_arg_q[ready_first_q[SLOT_W-1:0]];
			end
			OP_FINISH: begin
				m_tuser_q <= res_stat_q;
				m_tdata_q <= {4'd0, sat4(free_cnt_q), sat4(ready_cnt_q), sat4(moved_q),
					oa_q, oh_q};
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_pool_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ready_cnt_q) + 32'(free_cnt_q)) <= SLOTS)
		else $error("ready and free counts exceed pool");
	a_ready_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_first_q == NONE_IDX) == (ready_last_q == NONE_IDX))
		else $error("ready head and tail disagree");
	a_ready_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_cnt_q == '0) == (ready_first_q == NONE_IDX))
		else $error("ready count out of step with ready list");
	a_free_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(free_cnt_q == '0) == (free_first_q == NONE_IDX))
		else $error("free count out of step with free list");
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |=> m_tvalid_q)
		else $error("finished word not presented");
`endif

endmodule

FILE: hw/rtl/delayed_task_timer_queue_top.sv
// A pop unlinks the ready head and returns its slot to the free list; a tick advances time
// and moves each due waiting task onto the ready queue; a schedule takes a free slot and
// appends it to the ready queue if its delay is zero, else walks the waiting list to insert it.
// Throughput: one request in flight; the next is taken once the result is queued.
// A schedule walks the waiting list one linked entry per cycle; a held result word stalls the finish.
// Reset (arst_n low, asynchronous): all slots free, lists empty, time zero.
// ---------------------------------------------------------------------------
// delayed_task_timer_queue_top
// Task scheduler with free list, deadline-sorted waiting list and ready FIFO.
// ---------------------------------------------------------------------------
module delayed_task_timer_queue_top import dttq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // delay, task_handle, task_arg
	input  logic [1:0]            s_tuser,  // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_handle, out_arg, moved_count,
	                                        // ready_count, free_count
	output logic [1:0]            m_tuser   // status
);

	dttq_cmd_t cmd;
	dttq_sts_t sts;

	dttq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dttq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
